[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg
// types, codes and character helpers of the source token lexer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package stl_pkg;

   localparam int OFFSET_BITS_DEF = 20;
   localparam int LINE_BITS_DEF   = 20;
   localparam int COLUMN_BITS_DEF = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
   localparam int MAX_RESULTS     = 3;

   localparam logic [4:0] KIND_EOF     = 5'd0;
   localparam logic [4:0] KIND_NONE    = 5'd0;
   localparam logic [4:0] KIND_IDENT   = 5'd1;
   localparam logic [4:0] KIND_INT     = 5'd2;
   localparam logic [4:0] KIND_FLOAT   = 5'd3;
   localparam logic [4:0] KIND_STRING  = 5'd4;
   localparam logic [4:0] KIND_PLUS    = 5'd5;
   localparam logic [4:0] KIND_MINUS   = 5'd6;
   localparam logic [4:0] KIND_STAR    = 5'd7;
   localparam logic [4:0] KIND_SLASH   = 5'd8;
   localparam logic [4:0] KIND_PERCENT = 5'd9;
   localparam logic [4:0] KIND_LPAREN  = 5'd10;
   localparam logic [4:0] KIND_RPAREN  = 5'd11;
   localparam logic [4:0] KIND_LBRACE  = 5'd12;
   localparam logic [4:0] KIND_RBRACE  = 5'd13;
   localparam logic [4:0] KIND_LBRACK  = 5'd14;
   localparam logic [4:0] KIND_RBRACK  = 5'd15;
   localparam logic [4:0] KIND_SEMI    = 5'd16;
   localparam logic [4:0] KIND_COLON   = 5'd17;
   localparam logic [4:0] KIND_COMMA   = 5'd18;
   localparam logic [4:0] KIND_DOT     = 5'd19;
   localparam logic [4:0] KIND_ASSIGN  = 5'd20;
   localparam logic [4:0] KIND_EQ      = 5'd21;
   localparam logic [4:0] KIND_NOT     = 5'd22;
   localparam logic [4:0] KIND_NE      = 5'd23;
   localparam logic [4:0] KIND_LT      = 5'd24;
   localparam logic [4:0] KIND_LE      = 5'd25;
   localparam logic [4:0] KIND_GT      = 5'd26;
   localparam logic [4:0] KIND_GE      = 5'd27;
   localparam logic [4:0] KIND_ANDAND  = 5'd28;
   localparam logic [4:0] KIND_OROR    = 5'd29;
   localparam logic [4:0] KIND_ILLEGAL = 5'd30;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_COMMENT = 2'd1;
   localparam logic [1:0] ERR_STRING  = 2'd2;
   localparam logic [1:0] ERR_CHAR    = 2'd3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_MORE   = 8'h3E;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_INT, MODE_INT_DOT, MODE_FLOAT, MODE_STRING,
      MODE_STRING_ESC, MODE_SLASH, MODE_LINE_COMMENT, MODE_BLOCK,
      MODE_BLOCK_STAR, MODE_OP
   } mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [19:0] offset;
      logic [19:0] length;
      logic [19:0] line;
      logic [15:0] column;
      logic [1:0]  err;
      logic [7:0]  ebyte;
   } tok_type;

   typedef struct packed {
      tok_type [MAX_RESULTS-1:0] res;
      logic [1:0]                count;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'd32, [8'd9:8'd13]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic ident_start(input logic [7:0] c);
      return (c inside {["a":"z"], ["A":"Z"]}) || (c == CH_UNDER);
   endfunction

   function automatic logic ident_part(input logic [7:0] c);
      return ident_start(c) || is_digit(c);
   endfunction

   function automatic logic is_op_start(input logic [7:0] c);
      return c inside {CH_EQUAL, CH_BANG, CH_LESS, CH_MORE, CH_AMP, CH_BAR};
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "%":     k = KIND_PERCENT;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         "[":     k = KIND_LBRACK;
         "]":     k = KIND_RBRACK;
         ";":     k = KIND_SEMI;
         ":":     k = KIND_COLON;
         ",":     k = KIND_COMMA;
         CH_DOT:  k = KIND_DOT;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   // one-character kind of an operator lead, none for & and |
   function automatic logic [4:0] op_one(input logic [7:0] p);
      logic [4:0] k;
      case (p)
         CH_EQUAL: k = KIND_ASSIGN;
         CH_BANG:  k = KIND_NOT;
         CH_LESS:  k = KIND_LT;
         CH_MORE:  k = KIND_GT;
         default:  k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] op_two(input logic [7:0] p);
      logic [4:0] k;
      case (p)
         CH_EQUAL: k = KIND_EQ;
         CH_BANG:  k = KIND_NE;
         CH_LESS:  k = KIND_LE;
         CH_MORE:  k = KIND_GE;
         CH_AMP:   k = KIND_ANDAND;
         default:  k = KIND_OROR;
      endcase
      return k;
   endfunction

endpackage

[src/stl_req_if.sv]
// ----------------------------------------------------------------------------
// stl_req_if
// source byte channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   modport source (output valid, output source_byte, input ready);
   modport sink (input valid, input source_byte, output ready);
endinterface

[src/stl_rsp_if.sv]
// ----------------------------------------------------------------------------
// stl_rsp_if
// token channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface stl_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [19:0] token_offset;
   logic [19:0] token_length;
   logic [19:0] token_line;
   logic [15:0] token_column;
   logic [1:0]  error_code;
   logic [7:0]  error_byte;
   logic        last_of_run;
   modport source (output valid, output token_kind, output token_offset,
      output token_length, output token_line, output token_column,
      output error_code, output error_byte, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_offset,
      input token_length, input token_line, input token_column,
      input error_code, input error_byte, input last_of_run, output ready);
endinterface

[src/stl_front.sv]
// ----------------------------------------------------------------------------
// stl_front
// scanner: a byte a cycle unless full, tracks position, builds tokens it ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stl_front #(
   parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = stl_pkg::COLUMN_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   stl_req_if.sink             req_chan,
   input  stl_pkg::qstat_type  qstat,
   output logic                push,
   output stl_pkg::bundle_type push_data
);

   stl_pkg::mode_type      mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in, soff_ff, soff_in, doff_ff, doff_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, sline_ff, sline_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, scol_ff, scol_in, dcol_ff, dcol_in;
   logic [19:0]            len_ff, len_in;
   logic [7:0]             pend_ff, pend_in;
   logic                   accept;

   function automatic logic [19:0] satl(input logic [19:0] v);
      return (&v) ? v : v + 20'd1;
   endfunction

   function automatic stl_pkg::tok_type mk(input logic [4:0] kind,
      input logic [OFFSET_BITS-1:0] off, input logic [19:0] len,
      input logic [LINE_BITS-1:0] ln, input logic [COLUMN_BITS-1:0] col,
      input logic [1:0] err, input logic [7:0] eb);
      stl_pkg::tok_type t;
      t.kind   = kind;
      t.offset = 20'(off);
      t.length = len;
      t.line   = 20'(ln);
      t.column = 16'(col);
      t.err    = err;
      t.ebyte  = eb;
      return t;
   endfunction

   assign req_chan.ready = !qstat.full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      logic [7:0]       c;
      logic             agn, ended, vi, opm;
      logic [1:0]       n;
      stl_pkg::tok_type r0, r1, ri;
      c = req_chan.source_byte;
      agn = 1'b0; ended = 1'b0; vi = 1'b0; n = 2'd0; opm = 1'b0;
      r0 = '0; r1 = '0; ri = '0;
      mode_in = mode_ff; len_in = len_ff; pend_in = pend_ff;
      soff_in = soff_ff; sline_in = sline_ff; scol_in = scol_ff;
      doff_in = doff_ff; dcol_in = dcol_ff;
      case (mode_ff)
         stl_pkg::MODE_IDENT: begin
            if (stl_pkg::ident_part(c)) begin
               len_in = satl(len_ff);
            end else begin
               r0 = mk(stl_pkg::KIND_IDENT, soff_ff, len_ff, sline_ff, scol_ff,
                  stl_pkg::ERR_NONE, 8'd0);
               n = 2'd1; agn = 1'b1;
            end
         end
         stl_pkg::MODE_INT: begin
            if (stl_pkg::is_digit(c)) begin
               len_in = satl(len_ff);
            end else if (c == stl_pkg::CH_DOT) begin
               mode_in = stl_pkg::MODE_INT_DOT;
               doff_in = off_ff; dcol_in = col_ff;
            end else begin
               r0 = mk(stl_pkg::KIND_INT, soff_ff, len_ff, sline_ff, scol_ff,
                  stl_pkg::ERR_NONE, 8'd0);
               n = 2'd1; agn = 1'b1;
            end
         end
         stl_pkg::MODE_INT_DOT: begin
            if (stl_pkg::is_digit(c)) begin
               mode_in = stl_pkg::MODE_FLOAT;
               len_in = satl(satl(len_ff));
            end else begin
               r0 = mk(stl_pkg::KIND_INT, soff_ff, len_ff, sline_ff, scol_ff,
                  stl_pkg::ERR_NONE, 8'd0);
               r1 = mk(stl_pkg::KIND_DOT, doff_ff, 20'd1, sline_ff, dcol_ff,
                  stl_pkg::ERR_NONE, 8'd0);
               n = 2'd2; agn = 1'b1;
            end
         end
         stl_pkg::MODE_FLOAT: begin
            if (stl_pkg::is_digit(c)) begin
               len_in = satl(len_ff);
            end else begin
               r0 = mk(stl_pkg::KIND_FLOAT, soff_ff, len_ff, sline_ff, scol_ff,
                  stl_pkg::ERR_NONE, 8'd0);
               n = 2'd1; agn = 1'b1;
            end
         end
         stl_pkg::MODE_STRING: begin
            if (c == stl_pkg::CH_QUOTE) begin
               r0 = mk(stl_pkg::KIND_STRING, (&soff_ff) ? soff_ff : soff_ff + 1'b1,
                  len_ff, sline_ff, scol_ff, stl_pkg::ERR_NONE, 8'd0);
               n = 2'd1; mode_in = stl_pkg::MODE_IDLE;
            end else if (c == stl_pkg::CH_NUL || c == stl_pkg::CH_NL) begin
               r0 = mk(stl_pkg::KIND_ILLEGAL, soff_ff, 20'd0, sline_ff, scol_ff,
                  stl_pkg::ERR_STRING, 8'd0);
               n = 2'd1; agn = 1'b1;
            end else begin
               len_in = satl(len_ff);
               if (c == stl_pkg::CH_BSLASH) mode_in = stl_pkg::MODE_STRING_ESC;
            end
         end
         stl_pkg::MODE_STRING_ESC: begin
            if (c == stl_pkg::CH_NUL) begin
               r0 = mk(stl_pkg::KIND_ILLEGAL, soff_ff, 20'd0, sline_ff, scol_ff,
                  stl_pkg::ERR_STRING, 8'd0);
               n = 2'd1; agn = 1'b1;
            end else begin
               len_in = satl(len_ff);
               mode_in = stl_pkg::MODE_STRING;
            end
         end
         stl_pkg::MODE_SLASH: begin
            if (c == stl_pkg::CH_SLASH) begin
               mode_in = stl_pkg::MODE_LINE_COMMENT;
            end else if (c == stl_pkg::CH_STAR) begin
               mode_in = stl_pkg::MODE_BLOCK;
            end else begin
               r0 = mk(stl_pkg::KIND_SLASH, soff_ff, 20'd1, sline_ff, scol_ff,
                  stl_pkg::ERR_NONE, 8'd0);
               n = 2'd1; agn = 1'b1;
            end
         end
         stl_pkg::MODE_LINE_COMMENT: begin
            if (c == stl_pkg::CH_NL) mode_in = stl_pkg::MODE_IDLE;
            if (c == stl_pkg::CH_NUL) agn = 1'b1;
         end
         stl_pkg::MODE_BLOCK, stl_pkg::MODE_BLOCK_STAR: begin
            if (c == stl_pkg::CH_NUL) begin
               r0 = mk(stl_pkg::KIND_ILLEGAL, soff_ff, 20'd0, sline_ff, scol_ff,
                  stl_pkg::ERR_COMMENT, 8'd0);
               n = 2'd1; agn = 1'b1;
            end else if (mode_ff == stl_pkg::MODE_BLOCK_STAR && c == stl_pkg::CH_SLASH) begin
               mode_in = stl_pkg::MODE_IDLE;
            end else begin
               mode_in = (c == stl_pkg::CH_STAR) ? stl_pkg::MODE_BLOCK_STAR
                                                 : stl_pkg::MODE_BLOCK;
            end
         end
         stl_pkg::MODE_OP: begin
            opm = (pend_ff == stl_pkg::CH_AMP || pend_ff == stl_pkg::CH_BAR) ?
                  (c == pend_ff) : (c == stl_pkg::CH_EQUAL);
            mode_in = stl_pkg::MODE_IDLE;
            pend_in = 8'd0;
            n = 2'd1;
            if (opm) begin
               r0 = mk(stl_pkg::op_two(pend_ff), soff_ff, 20'd2, sline_ff, scol_ff,
                  stl_pkg::ERR_NONE, 8'd0);
            end else begin
               agn = 1'b1;
               if (stl_pkg::op_one(pend_ff) != stl_pkg::KIND_NONE)
                  r0 = mk(stl_pkg::op_one(pend_ff), soff_ff, 20'd1, sline_ff, scol_ff,
                     stl_pkg::ERR_NONE, 8'd0);
               else
                  r0 = mk(stl_pkg::KIND_ILLEGAL, soff_ff, 20'd0, sline_ff, scol_ff,
                     stl_pkg::ERR_CHAR, pend_ff);
            end
         end
         default: agn = 1'b1;
      endcase

      if (agn) begin
         mode_in = stl_pkg::MODE_IDLE;
         if (c == stl_pkg::CH_NUL) begin
            ri = mk(stl_pkg::KIND_EOF, off_ff, 20'd0, line_ff, col_ff,
               stl_pkg::ERR_NONE, 8'd0);
            vi = 1'b1; ended = 1'b1;
         end else if (stl_pkg::is_space(c)) begin
            vi = 1'b0;
         end else if (c == stl_pkg::CH_SLASH || stl_pkg::ident_start(c) ||
                      stl_pkg::is_digit(c) || c == stl_pkg::CH_QUOTE ||
                      stl_pkg::is_op_start(c)) begin
            soff_in = off_ff; sline_in = line_ff; scol_in = col_ff;
            len_in = 20'd1;
            if (c == stl_pkg::CH_SLASH) begin
               mode_in = stl_pkg::MODE_SLASH;
            end else if (stl_pkg::ident_start(c)) begin
               mode_in = stl_pkg::MODE_IDENT;
            end else if (stl_pkg::is_digit(c)) begin
               mode_in = stl_pkg::MODE_INT;
            end else if (c == stl_pkg::CH_QUOTE) begin
               mode_in = stl_pkg::MODE_STRING;
               len_in = 20'd0;
            end else begin
               mode_in = stl_pkg::MODE_OP;
               pend_in = c;
            end
         end else if (stl_pkg::single_kind(c) != stl_pkg::KIND_NONE) begin
            ri = mk(stl_pkg::single_kind(c), off_ff, 20'd1, line_ff, col_ff,
               stl_pkg::ERR_NONE, 8'd0);
            vi = 1'b1;
         end else begin
            ri = mk(stl_pkg::KIND_ILLEGAL, off_ff, 20'd0, line_ff, col_ff,
               stl_pkg::ERR_CHAR, c);
            vi = 1'b1;
         end
      end

      push_data.res[0] = (n != 2'd0) ? r0 : ri;
      push_data.res[1] = (n == 2'd2) ? r1 : ri;
      push_data.res[2] = ri;
      push_data.count  = n + {1'b0, vi};
      push = accept && (push_data.count != 2'd0);

      if (ended) begin
         mode_in = stl_pkg::MODE_IDLE;
         off_in = '0; line_in = LINE_BITS'(1); col_in = COLUMN_BITS'(1);
         soff_in = '0; sline_in = LINE_BITS'(1); scol_in = COLUMN_BITS'(1);
         len_in = 20'd0; doff_in = '0; dcol_in = COLUMN_BITS'(1); pend_in = 8'd0;
      end else begin
         off_in = (&off_ff) ? off_ff : off_ff + 1'b1;
         if (c == stl_pkg::CH_NL) begin
            line_in = (&line_ff) ? line_ff : line_ff + 1'b1;
            col_in = COLUMN_BITS'(1);
         end else begin
            line_in = line_ff;
            col_in = (&col_ff) ? col_ff : col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stl_pkg::MODE_IDLE;
         off_ff <= '0; line_ff <= LINE_BITS'(1); col_ff <= COLUMN_BITS'(1);
         soff_ff <= '0; sline_ff <= LINE_BITS'(1); scol_ff <= COLUMN_BITS'(1);
         len_ff <= 20'd0; doff_ff <= '0; dcol_ff <= COLUMN_BITS'(1); pend_ff <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         off_ff <= off_in; line_ff <= line_in; col_ff <= col_in;
         soff_ff <= soff_in; sline_ff <= sline_in; scol_ff <= scol_in;
         len_ff <= len_in; doff_ff <= doff_in; dcol_ff <= dcol_in; pend_ff <= pend_in;
      end
   end

endmodule

[src/stl_queue.sv]
// ----------------------------------------------------------------------------
// stl_queue
// short queue of token bundles between scanner and output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stl_pkg::bundle_type push_data,
   input  logic                pop,
   output stl_pkg::bundle_type head,
   output stl_pkg::qstat_type  qstat
);

   stl_pkg::bundle_type              mem_ff [stl_pkg::QUEUE_DEPTH];
   logic [stl_pkg::QPTR_BITS-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [stl_pkg::QPTR_BITS:0]      lvl_ff, lvl_in;

   assign head        = mem_ff[rd_ff];
   assign qstat.full  = (lvl_ff == (stl_pkg::QPTR_BITS+1)'(stl_pkg::QUEUE_DEPTH));
   assign qstat.empty = (lvl_ff == '0);

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      lvl_in = lvl_ff + {{stl_pkg::QPTR_BITS{1'b0}}, push}
                      - {{stl_pkg::QPTR_BITS{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; lvl_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; lvl_ff <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

[src/stl_back.sv]
// ----------------------------------------------------------------------------
// stl_back
// output side: sends the head bundle's words one per ready cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stl_back (
   input  logic                clock,
   input  logic                reset,
   input  stl_pkg::bundle_type head,
   input  stl_pkg::qstat_type  qstat,
   output logic                pop,
   stl_rsp_if.source           rsp_chan
);

   logic [1:0]       idx_ff, idx_in;
   logic             last;
   stl_pkg::tok_type cur;

   always_comb begin
      cur  = head.res[idx_ff];
      last = (idx_ff == head.count - 2'd1);
      rsp_chan.valid        = !qstat.empty;
      rsp_chan.token_kind   = cur.kind;
      rsp_chan.token_offset = cur.offset;
      rsp_chan.token_length = cur.length;
      rsp_chan.token_line   = cur.line;
      rsp_chan.token_column = cur.column;
      rsp_chan.error_code   = cur.err;
      rsp_chan.error_byte   = cur.ebyte;
      rsp_chan.last_of_run  = last;
      pop = rsp_chan.valid && rsp_chan.ready && last;
      if (rsp_chan.valid && rsp_chan.ready)
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      else
         idx_in = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[src/source_token_lexer.sv]
// ----------------------------------------------------------------------------
// source_token_lexer
// streaming lexer: one source byte per word in, tokens out
// ----------------------------------------------------------------------------
// channel   dir  payload                                   word
// req_chan  in   source_byte                               one source byte
// rsp_chan  out  token_kind .. error_byte, last_of_run     one token or error
//
// one byte accepted per cycle while the bundle queue has room
// a byte gives zero to three tokens; the output sends one per ready cycle, so
// the output port sets the rate when bytes end tokens back to back
// a byte's tokens are registered in the bundle queue and sent after earlier ones
// synchronous reset returns the scanner to idle at offset 0, line 1, column 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module source_token_lexer #(
   parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = stl_pkg::COLUMN_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   stl_req_if.sink   req_chan,
   stl_rsp_if.source rsp_chan
);

   logic                push, pop;
   stl_pkg::bundle_type push_data, head;
   stl_pkg::qstat_type  qstat;

   stl_front #(
      .OFFSET_BITS(OFFSET_BITS),
      .LINE_BITS  (LINE_BITS),
      .COLUMN_BITS(COLUMN_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .qstat    (qstat),
      .push     (push),
      .push_data(push_data)
   );

   stl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   stl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .qstat   (qstat),
      .pop     (pop),
      .rsp_chan(rsp_chan)
   );

   `ASSERT_SAME(a_eof_last, clock, reset,
      rsp_chan.valid && rsp_chan.token_kind == stl_pkg::KIND_EOF, rsp_chan.last_of_run)
   `ASSERT_SAME(a_err_illegal, clock, reset,
      rsp_chan.valid && rsp_chan.error_code != stl_pkg::ERR_NONE,
      rsp_chan.token_kind == stl_pkg::KIND_ILLEGAL)
   `ASSERT_SAME(a_ebyte_char, clock, reset,
      rsp_chan.valid && rsp_chan.error_code != stl_pkg::ERR_CHAR,
      rsp_chan.error_byte == 8'd0)
   `ASSERT_NEXT(a_full_no_push, clock, reset, qstat.full && !pop, !push || !qstat.full)

endmodule

[tb/tb_source_token_lexer.sv]
// ----------------------------------------------------------------------------
// tb_source_token_lexer
// drives source bytes with random gaps, predicts tokens and checks each word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_source_token_lexer;
   import stl_pkg::*;

   typedef struct packed {
      logic [4:0]  kind;
      logic [19:0] offset;
      logic [19:0] length;
      logic [19:0] line;
      logic [15:0] column;
      logic [1:0]  err;
      logic [7:0]  ebyte;
      logic        last;
   } token_rec;

   class token_board;
      token_rec   pending[$];
      int         errors;
      mode_type   mode;
      logic [19:0] pos_off, pos_line, st_off, st_line, dot_off;
      logic [15:0] pos_col, st_col, dot_col;
      logic [31:0] tlen;
      logic [7:0]  lead;
      token_rec   batch[$];

      function void clear();
         mode = MODE_IDLE;
         pos_off = 0; pos_line = 1; pos_col = 1;
         st_off = 0; st_line = 1; st_col = 1;
         tlen = 0; dot_off = 0; dot_col = 1; lead = 0;
      endfunction

      function new();
         errors = 0;
         clear();
      endfunction

      function logic [31:0] bump(logic [31:0] v, int bits);
         logic [31:0] mx;
         mx = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
         return (v >= mx) ? mx : v + 1;
      endfunction

      function void put(logic [4:0] k, logic [19:0] o, logic [31:0] l, logic [19:0] ln,
                        logic [15:0] c, logic [1:0] e, logic [7:0] b);
         token_rec t;
         t.kind = k; t.offset = o;
         t.length = (l > 32'hFFFFF) ? 20'hFFFFF : l[19:0];
         t.line = ln; t.column = c; t.err = e; t.ebyte = b; t.last = 0;
         if (batch.size() < MAX_RESULTS) batch.push_back(t);
      endfunction

      function void start(mode_type m, logic [31:0] l);
         mode = m; st_off = pos_off; st_line = pos_line; st_col = pos_col; tlen = l;
      endfunction

      function void note_byte(logic [7:0] c);
         bit again, ended;
         logic [4:0] k;
         logic [7:0] p;
         again = 1; ended = 0;
         batch = {};
         while (again && !ended) begin
            again = 0;
            case (mode)
               MODE_IDENT: begin
                  if (is_alnum(c)) tlen = bump(tlen, 32);
                  else begin
                     put(KIND_IDENT, st_off, tlen, st_line, st_col, ERR_NONE, 0);
                     mode = MODE_IDLE; again = 1;
                  end
               end
               MODE_INT: begin
                  if (digit(c)) tlen = bump(tlen, 32);
                  else if (c == CH_DOT) begin
                     mode = MODE_INT_DOT; dot_off = pos_off; dot_col = pos_col;
                  end else begin
                     put(KIND_INT, st_off, tlen, st_line, st_col, ERR_NONE, 0);
                     mode = MODE_IDLE; again = 1;
                  end
               end
               MODE_INT_DOT: begin
                  if (digit(c)) begin
                     mode = MODE_FLOAT; tlen = bump(bump(tlen, 32), 32);
                  end else begin
                     put(KIND_INT, st_off, tlen, st_line, st_col, ERR_NONE, 0);
                     put(KIND_DOT, dot_off, 1, st_line, dot_col, ERR_NONE, 0);
                     mode = MODE_IDLE; again = 1;
                  end
               end
               MODE_FLOAT: begin
                  if (digit(c)) tlen = bump(tlen, 32);
                  else begin
                     put(KIND_FLOAT, st_off, tlen, st_line, st_col, ERR_NONE, 0);
                     mode = MODE_IDLE; again = 1;
                  end
               end
               MODE_STRING: begin
                  if (c == CH_QUOTE) begin
                     put(KIND_STRING, 20'(bump(32'(st_off), 20)), tlen, st_line, st_col,
                         ERR_NONE, 0);
                     mode = MODE_IDLE;
                  end else if (c == CH_NUL || c == CH_NL) begin
                     put(KIND_ILLEGAL, st_off, 0, st_line, st_col, ERR_STRING, 0);
                     mode = MODE_IDLE; again = 1;
                  end else begin
                     tlen = bump(tlen, 32);
                     if (c == CH_BSLASH) mode = MODE_STRING_ESC;
                  end
               end
               MODE_STRING_ESC: begin
                  if (c == CH_NUL) begin
                     put(KIND_ILLEGAL, st_off, 0, st_line, st_col, ERR_STRING, 0);
                     mode = MODE_IDLE; again = 1;
                  end else begin
                     tlen = bump(tlen, 32); mode = MODE_STRING;
                  end
               end
               MODE_SLASH: begin
                  if (c == CH_SLASH) mode = MODE_LINE_COMMENT;
                  else if (c == CH_STAR) mode = MODE_BLOCK;
                  else begin
                     put(KIND_SLASH, st_off, 1, st_line, st_col, ERR_NONE, 0);
                     mode = MODE_IDLE; again = 1;
                  end
               end
               MODE_LINE_COMMENT: begin
                  if (c == CH_NL || c == CH_NUL) begin
                     mode = MODE_IDLE; again = (c == CH_NUL);
                  end
               end
               MODE_BLOCK, MODE_BLOCK_STAR: begin
                  if (c == CH_NUL) begin
                     put(KIND_ILLEGAL, st_off, 0, st_line, st_col, ERR_COMMENT, 0);
                     mode = MODE_IDLE; again = 1;
                  end else if (mode == MODE_BLOCK_STAR && c == CH_SLASH) mode = MODE_IDLE;
                  else mode = (c == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
               end
               MODE_OP: begin
                  p = lead;
                  mode = MODE_IDLE; lead = 0;
                  if ((p == CH_AMP || p == CH_BAR) ? (c == p) : (c == CH_EQUAL))
                     put(pair_kind(p), st_off, 2, st_line, st_col, ERR_NONE, 0);
                  else begin
                     k = lone_kind(p);
                     if (k != KIND_NONE) put(k, st_off, 1, st_line, st_col, ERR_NONE, 0);
                     else put(KIND_ILLEGAL, st_off, 0, st_line, st_col, ERR_CHAR, p);
                     again = 1;
                  end
               end
               default: begin
                  mode = MODE_IDLE;
                  if (c == CH_NUL) begin
                     put(KIND_EOF, pos_off, 0, pos_line, pos_col, ERR_NONE, 0);
                     ended = 1;
                  end else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
                  end else if (c == CH_SLASH) start(MODE_SLASH, 1);
                  else if (c == "_" || alpha(c)) start(MODE_IDENT, 1);
                  else if (digit(c)) start(MODE_INT, 1);
                  else if (c == CH_QUOTE) start(MODE_STRING, 0);
                  else if (c == CH_EQUAL || c == CH_BANG || c == CH_LESS || c == CH_MORE
                           || c == CH_AMP || c == CH_BAR) begin
                     start(MODE_OP, 1); lead = c;
                  end else begin
                     k = punct_kind(c);
                     if (k != KIND_NONE) put(k, pos_off, 1, pos_line, pos_col, ERR_NONE, 0);
                     else put(KIND_ILLEGAL, pos_off, 0, pos_line, pos_col, ERR_CHAR, c);
                  end
               end
            endcase
         end
         if (ended) clear();
         else begin
            pos_off = 20'(bump(32'(pos_off), 20));
            if (c == CH_NL) begin
               pos_line = 20'(bump(32'(pos_line), 20)); pos_col = 1;
            end else pos_col = 16'(bump(32'(pos_col), 16));
         end
         if (batch.size() > 0) batch[batch.size()-1].last = 1;
         foreach (batch[i]) pending.push_back(batch[i]);
      endfunction

      function bit digit(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
      function bit alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction
      function bit is_alnum(logic [7:0] c); return alpha(c) || digit(c) || c == "_"; endfunction

      function logic [4:0] punct_kind(logic [7:0] c);
         case (c)
            "+": return KIND_PLUS;   "-": return KIND_MINUS;  "*": return KIND_STAR;
            "%": return KIND_PERCENT; "(": return KIND_LPAREN; ")": return KIND_RPAREN;
            "{": return KIND_LBRACE; "}": return KIND_RBRACE; "[": return KIND_LBRACK;
            "]": return KIND_RBRACK; ";": return KIND_SEMI;   ":": return KIND_COLON;
            ",": return KIND_COMMA;  ".": return KIND_DOT;
            default: return KIND_NONE;
         endcase
      endfunction

      function logic [4:0] lone_kind(logic [7:0] p);
         case (p)
            CH_EQUAL: return KIND_ASSIGN; CH_BANG: return KIND_NOT;
            CH_LESS: return KIND_LT;      CH_MORE: return KIND_GT;
            default: return KIND_NONE;
         endcase
      endfunction

      function logic [4:0] pair_kind(logic [7:0] p);
         case (p)
            CH_EQUAL: return KIND_EQ;  CH_BANG: return KIND_NE;
            CH_LESS: return KIND_LE;   CH_MORE: return KIND_GE;
            CH_AMP: return KIND_ANDAND;
            default: return KIND_OROR;
         endcase
      endfunction

      function void check_token(token_rec got);
         token_rec w;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected token kind %0d", got.kind);
            return;
         end
         w = pending.pop_front();
         if (w !== got) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp k%0d o%0d l%0d ln%0d c%0d e%0d b%0h t%0d / got k%0d o%0d l%0d ln%0d c%0d e%0d b%0h t%0d",
                  w.kind, w.offset, w.length, w.line, w.column, w.err, w.ebyte, w.last,
                  got.kind, got.offset, got.length, got.line, got.column, got.err,
                  got.ebyte, got.last);
         end
      endfunction
   endclass

   logic clock, reset;
   stl_req_if req_chan();
   stl_rsp_if rsp_chan();
   token_board board;
   int cycles;
   int hold;
   bit feed_done;
   byte unsigned text[$];

   source_token_lexer uut (.clock(clock), .reset(reset), .req_chan(req_chan),
      .rsp_chan(rsp_chan));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic add_str(string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endtask

   // a random well-formed fragment, now and then broken
   task automatic add_piece();
      int r, n;
      string lead_set, pair_set, punct_set;
      lead_set = "=!<>&|";
      pair_set = "=&|";
      punct_set = "+-*%(){}[];:,./";
      r = $urandom_range(0, 15);
      n = $urandom_range(1, 5);
      case (r)
         0: for (int i = 0; i < n; i++) text.push_back(8'("a" + $urandom_range(0, 25)));
         1: for (int i = 0; i < n; i++) text.push_back(8'("0" + $urandom_range(0, 9)));
         2: begin
            if ($urandom_range(0, 1)) add_str("3.14");
            else add_str("7.x");
         end
         3: begin
            text.push_back(CH_QUOTE);
            for (int i = 0; i < n; i++)
               text.push_back($urandom_range(0, 4) == 0 ? CH_BSLASH : 8'("A" + i));
            text.push_back(CH_QUOTE);
         end
         4: add_str("// note\n");
         5: add_str("/* b * x */");
         6: text.push_back(" ");
         7: text.push_back(CH_NL);
         8: begin
            text.push_back(lead_set[$urandom_range(0, 5)]);
            if ($urandom_range(0, 1)) text.push_back(pair_set[$urandom_range(0, 2)]);
         end
         9: text.push_back(punct_set[$urandom_range(0, 14)]);
         10: text.push_back(8'($urandom_range(1, 255)));
         11: text.push_back(8'($urandom_range(128, 255)));
         12: add_str("_Z9");
         13: add_str("\"bad\n");
         14: text.push_back("\t");
         default: begin
            text.push_back(CH_NUL);
         end
      endcase
   endtask

   task automatic send_text();
      int g;
      while (text.size() > 0) begin
         g = pick_gap();
         if (g > 0) begin
            req_chan.valid <= 0;
            repeat (g) @(posedge clock);
         end
         req_chan.valid <= 1;
         req_chan.source_byte <= text[0];
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         board.note_byte(text.pop_front());
      end
      req_chan.valid <= 0;
   endtask

   always @(posedge clock) begin
      token_rec got;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind = rsp_chan.token_kind; got.offset = rsp_chan.token_offset;
            got.length = rsp_chan.token_length; got.line = rsp_chan.token_line;
            got.column = rsp_chan.token_column; got.err = rsp_chan.error_code;
            got.ebyte = rsp_chan.error_byte; got.last = rsp_chan.last_of_run;
            board.check_token(got);
         end
         if (hold > 0) begin
            rsp_chan.ready <= 0;
            hold <= hold - 1;
         end else begin
            rsp_chan.ready <= 1;
            hold <= feed_done ? 0 : pick_gap();
         end
      end
      if (cycles > 200000) begin
         $display("tb_source_token_lexer: errors");
         $finish;
      end
   end

   initial begin
      board = new();
      cycles = 0;
      hold = 0;
      feed_done = 0;
      reset = 1;
      req_chan.valid = 0;
      req_chan.source_byte = 0;
      rsp_chan.ready = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed
      add_str("ab_1 12 3.5 4.a \"x\\\"y\" /*c*/ //l\n== != <= >= && || = ! < > & |");
      text.push_back(8'hFF);
      text.push_back(CH_NUL);
      add_str("\"un\n/* open");
      text.push_back(CH_NUL);
      add_str("\"s\\");
      text.push_back(CH_NUL);
      add_str("9.");
      text.push_back(CH_NUL);
      send_text();
      for (int i = 0; i < 55; i++) add_piece();
      text.push_back(CH_NUL);
      send_text();
      feed_done = 1;
      while (board.pending.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_source_token_lexer: clean");
      else
         $display("tb_source_token_lexer: errors");
      $finish;
   end
endmodule
